/* hdl/exposure_timer_menu_controller_assert.svh */
// assertion macros for the exposure timer menu controller
// no dependencies; included by the top level inside its module body
`ifndef EXPOSURE_TIMER_MENU_CONTROLLER_ASSERT_SVH
`define EXPOSURE_TIMER_MENU_CONTROLLER_ASSERT_SVH

// same-cycle implication
`define ETMC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ETMC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/etmc_pkg.sv */
// shared types, menu codes and constants for the exposure timer menu controller
// no dependencies; imported by etmc_next, the top level and the testbench
`default_nettype none

package etmc_pkg;

   localparam int MENU_W  = 4;
   localparam int TIME_W  = 15;
   localparam int TICK_W  = 8;
   localparam int STEP_W  = 11;
   localparam int CSR_W   = 15;
   localparam int CSR_IDX_W = 1;

   typedef logic [MENU_W-1:0] etmc_menu_type;

   // menu positions
   localparam etmc_menu_type MENU_RUN_ENTRY   = 4'd0;
   localparam etmc_menu_type MENU_RUN_VIEW    = 4'd1;
   localparam etmc_menu_type MENU_SET_ENTRY   = 4'd2;
   localparam etmc_menu_type MENU_SET_VIEW    = 4'd3;
   localparam etmc_menu_type MENU_S1_ENTRY    = 4'd4;
   localparam etmc_menu_type MENU_S1_ADJ      = 4'd5;
   localparam etmc_menu_type MENU_S10_ENTRY   = 4'd6;
   localparam etmc_menu_type MENU_S10_ADJ     = 4'd7;
   localparam etmc_menu_type MENU_S100_ENTRY  = 4'd8;
   localparam etmc_menu_type MENU_S100_ADJ    = 4'd9;
   localparam etmc_menu_type MENU_S1000_ENTRY = 4'd10;
   localparam etmc_menu_type MENU_S1000_ADJ   = 4'd11;
   localparam etmc_menu_type MENU_CLEAR       = 4'd12;

   // item kinds
   localparam logic CMD_UI   = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_TIME = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS    = 1'd1;

   localparam logic [TIME_W-1:0] MAX_TIME_RESET = 15'd30000;
   localparam logic [TICK_W-1:0] TICKS_RESET    = 8'd10;

   typedef struct packed {
      logic cmd;
      logic button;
      logic enc_moved;
      logic enc_dir;
   } etmc_item_type;

   typedef struct packed {
      etmc_menu_type     menu;
      logic [TIME_W-1:0] set_time;
      logic [TIME_W-1:0] time_left;
      logic              run;
      logic [TICK_W-1:0] tick;
      logic              lamp;
   } etmc_state_type;

   // setpoint step of an adjust state, zero elsewhere
   function automatic logic [STEP_W-1:0] etmc_step(input etmc_menu_type menu);
      logic [STEP_W-1:0] step;
      step = '0;
      case (menu)
         MENU_S1_ADJ:    step = 11'd1;
         MENU_S10_ADJ:   step = 11'd10;
         MENU_S100_ADJ:  step = 11'd100;
         MENU_S1000_ADJ: step = 11'd1000;
         default:        step = '0;
      endcase
      return step;
   endfunction

endpackage

`default_nettype wire

/* hdl/etmc_next.sv */
// next-state logic of the exposure timer: menu walk, clamped setpoint adjust, countdown
// depends on etmc_pkg
`default_nettype none

module etmc_next (
   input  etmc_pkg::etmc_state_type     cur,
   input  etmc_pkg::etmc_item_type      item,
   input  logic [etmc_pkg::TIME_W-1:0] max_time,
   input  logic [etmc_pkg::TICK_W-1:0] ticks_per_unit,
   input  logic [etmc_pkg::TICK_W-1:0] tick_mod,
   output etmc_pkg::etmc_state_type     nxt
);
   import etmc_pkg::*;

   logic [STEP_W-1:0] step;
   logic [TIME_W:0]   up_sum;
   logic              dn_ok;
   logic [TIME_W-1:0] dn_diff;
   logic [TIME_W:0]   cand;
   logic [TIME_W-1:0] adj_time;
   logic [TICK_W-1:0] tick_inc;
   logic              tick_wrap;
   logic [TIME_W-1:0] tl_dec;
   logic [TIME_W-1:0] tl_clamp;

   // setpoint adjust, wide sum then clamp to 0..max_time
   always_comb begin
      step    = etmc_step(cur.menu);
      up_sum  = {1'b0, cur.set_time} + {{(TIME_W+1-STEP_W){1'b0}}, step};
      dn_ok   = cur.set_time >= {{(TIME_W-STEP_W){1'b0}}, step};
      dn_diff = cur.set_time - {{(TIME_W-STEP_W){1'b0}}, step};
      if (item.enc_dir) begin
         cand = up_sum;
      end else if (dn_ok) begin
         cand = {1'b0, dn_diff};
      end else begin
         cand = '0;
      end
      adj_time = (cand > {1'b0, max_time}) ? max_time : cand[TIME_W-1:0];
   end

   // tick_mod is the counter already reduced below ticks_per_unit; zero wraps the full 8 bits
   assign tick_inc  = tick_mod + 8'd1;
   assign tick_wrap = (tick_inc == ticks_per_unit);
   assign tl_dec    = cur.time_left - 15'd1;
   assign tl_clamp  = (tl_dec > max_time) ? max_time : tl_dec;

   always_comb begin
      nxt = cur;
      if (item.cmd == CMD_TICK) begin
         if (cur.run && (cur.time_left != '0)) begin
            nxt.lamp = 1'b1;
            nxt.tick = tick_wrap ? '0 : tick_inc;
            if (tick_wrap) begin
               nxt.time_left = tl_clamp;
            end
         end else begin
            nxt.lamp = 1'b0;
            nxt.tick = '0;
         end
      end else if (cur.menu > MENU_CLEAR) begin
         nxt.menu = MENU_RUN_ENTRY;
      end else if (item.button) begin
         unique case (cur.menu) inside
            MENU_RUN_ENTRY: begin
               nxt.run       = 1'b1;
               nxt.time_left = cur.set_time;
               nxt.menu      = MENU_RUN_VIEW;
            end
            MENU_RUN_VIEW: begin
               nxt.run       = 1'b0;
               nxt.time_left = '0;
               nxt.menu      = MENU_RUN_ENTRY;
            end
            MENU_CLEAR: begin
               nxt.set_time = '0;
            end
            MENU_SET_ENTRY, MENU_S1_ENTRY, MENU_S10_ENTRY, MENU_S100_ENTRY,
            MENU_S1000_ENTRY: begin
               nxt.menu = cur.menu + 4'd1;
            end
            default: begin
               nxt.menu = cur.menu - 4'd1;
            end
         endcase
      end else if (item.enc_moved) begin
         unique case (cur.menu) inside
            MENU_RUN_ENTRY:   nxt.menu = MENU_SET_ENTRY;
            MENU_RUN_VIEW:    nxt.menu = cur.menu;
            MENU_SET_ENTRY:   nxt.menu = MENU_RUN_ENTRY;
            MENU_SET_VIEW:    nxt.menu = item.enc_dir ? MENU_S1_ENTRY : MENU_CLEAR;
            MENU_S1_ENTRY:    nxt.menu = item.enc_dir ? MENU_S10_ENTRY : MENU_SET_VIEW;
            MENU_S10_ENTRY:   nxt.menu = item.enc_dir ? MENU_S100_ENTRY : MENU_S1_ENTRY;
            MENU_S100_ENTRY:  nxt.menu = item.enc_dir ? MENU_S1000_ENTRY : MENU_S10_ENTRY;
            MENU_S1000_ENTRY: nxt.menu = item.enc_dir ? MENU_CLEAR : MENU_S100_ENTRY;
            MENU_CLEAR:       nxt.menu = item.enc_dir ? MENU_SET_VIEW : MENU_S1000_ENTRY;
            default:          nxt.set_time = adj_time;
         endcase
      end
   end

endmodule

`default_nettype wire

/* hdl/exposure_timer_menu_controller.sv */
// exposure timer menu controller top level: input word register, state/result register,
// config registers and tick counter renormalization; depends on etmc_pkg, etmc_next
//
//   channel  dir  handshake            payload
//   req      in   req_valid/req_stall  cmd, button, enc_moved, enc_dir
//   rsp      out  rsp_valid/rsp_stall  menu_state, setpoint, remaining, running, lamp_on
//   csr      in   csr_write            csr_index, csr_wdata
//
// one word per cycle sustained while rsp is not stalled and no renormalization runs; a result reaches rsp via
// the input and state/result registers; req takes a word while a result waits on a stalled rsp, as long as the
// input register is free; writing ticks_per_unit renormalizes the tick counter, req is stalled meanwhile
// synchronous active-high reset: menu at run entry, times zero, lamp off, config at defaults
`default_nettype none

module exposure_timer_menu_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_cmd,
   input  logic                           req_button,
   input  logic                           req_enc_moved,
   input  logic                           req_enc_dir,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [etmc_pkg::MENU_W-1:0]    rsp_menu_state,
   output logic [etmc_pkg::TIME_W-1:0]    rsp_setpoint,
   output logic [etmc_pkg::TIME_W-1:0]    rsp_remaining,
   output logic                           rsp_running,
   output logic                           rsp_lamp_on,
   input  logic                           csr_write,
   input  logic [etmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [etmc_pkg::CSR_W-1:0]     csr_wdata
);
   import etmc_pkg::*;

   `include "exposure_timer_menu_controller_assert.svh"

   // input word register
   logic           s1_valid_ff, s1_valid_in;
   etmc_item_type  s1_item_ff;

   // controller state; it is also the result payload
   etmc_state_type state_ff, state_in, state_next;
   logic           rsp_valid_ff, rsp_valid_in;

   // config
   logic [TIME_W-1:0] max_time_ff;
   logic [TICK_W-1:0] ticks_ff;

   // tick counter reduced modulo ticks_per_unit; the state keeps the raw count,
   // which a later ticks_per_unit write reduces again from scratch
   logic [TICK_W-1:0] tick_mod_ff, tick_mod_in;

   // tick counter renormalization after a ticks_per_unit write (remainder by long division)
   logic              norm_busy_ff, norm_busy_in;
   logic [2:0]        norm_step_ff, norm_step_in;
   logic [TICK_W-1:0] norm_rem_ff, norm_rem_in;
   logic [TIME_W-1:0] norm_div;
   logic              norm_ge;
   logic [TICK_W-1:0] norm_sub;

   logic accept;
   logic advance;
   logic ticks_write;

   // a word moves to the result register when the result slot is free or being taken and no renormalization runs
   assign advance     = s1_valid_ff & ~norm_busy_ff & (~rsp_valid_ff | ~rsp_stall);
   assign req_stall   = norm_busy_ff | (s1_valid_ff & ~advance);
   assign accept      = req_valid & ~req_stall;
   assign ticks_write = csr_write & (csr_index == CSR_TICKS);

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   etmc_next u_next (
      .cur            (state_ff),
      .item           (s1_item_ff),
      .max_time       (max_time_ff),
      .ticks_per_unit (ticks_ff),
      .tick_mod       (tick_mod_ff),
      .nxt            (state_next)
   );

   // subtract ticks_per_unit << step from the partial remainder when it fits
   assign norm_div = {{(TIME_W-TICK_W){1'b0}}, ticks_ff} << norm_step_ff;
   assign norm_ge  = {{(TIME_W-TICK_W){1'b0}}, norm_rem_ff} >= norm_div;
   assign norm_sub = norm_ge ? (norm_rem_ff - norm_div[TICK_W-1:0]) : norm_rem_ff;

   always_comb begin
      state_in     = state_ff;
      tick_mod_in  = tick_mod_ff;
      norm_busy_in = norm_busy_ff;
      norm_step_in = norm_step_ff;
      norm_rem_in  = norm_rem_ff;
      if (advance) begin
         state_in = state_next;
         // a tick leaves the counter below ticks_per_unit, a sample leaves it alone
         if (s1_item_ff.cmd == CMD_TICK) begin
            tick_mod_in = state_next.tick;
         end
      end else if (norm_busy_ff) begin
         norm_rem_in  = norm_sub;
         norm_step_in = norm_step_ff - 3'd1;
         if (norm_step_ff == 3'd0) begin
            norm_busy_in = 1'b0;
            tick_mod_in  = norm_sub;
         end
      end
      // always start from the raw count, even when a write lands mid-way
      if (ticks_write) begin
         norm_busy_in = 1'b1;
         norm_step_in = 3'd7;
         norm_rem_in  = state_ff.tick;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '0;
         tick_mod_ff  <= '0;
         max_time_ff  <= MAX_TIME_RESET;
         ticks_ff     <= TICKS_RESET;
         norm_busy_ff <= 1'b0;
         norm_step_ff <= '0;
         norm_rem_ff  <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
         tick_mod_ff  <= tick_mod_in;
         norm_busy_ff <= norm_busy_in;
         norm_step_ff <= norm_step_in;
         norm_rem_ff  <= norm_rem_in;
         if (csr_write && (csr_index == CSR_MAX_TIME)) begin
            max_time_ff <= csr_wdata[TIME_W-1:0];
         end
         if (ticks_write) begin
            ticks_ff <= csr_wdata[TICK_W-1:0];
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff <= '{cmd: req_cmd, button: req_button,
                         enc_moved: req_enc_moved, enc_dir: req_enc_dir};
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_menu_state = state_ff.menu;
   assign rsp_setpoint   = state_ff.set_time;
   assign rsp_remaining  = state_ff.time_left;
   assign rsp_running    = state_ff.run;
   assign rsp_lamp_on    = state_ff.lamp;

   // an encoder adjust always lands inside 0..max_time
   `ETMC_ASSERT_NEXT(a_adjust_clamped, clock, reset, advance && (s1_item_ff.cmd == CMD_UI) && !s1_item_ff.button && s1_item_ff.enc_moved && (etmc_step(state_ff.menu) != '0), state_ff.set_time <= max_time_ff, "adjusted setpoint above max_time")

   // outside renormalization the reduced tick counter stays below ticks_per_unit
   `ETMC_ASSERT_NOW(a_tick_below_period, clock, reset, !norm_busy_ff && (ticks_ff != '0), tick_mod_ff < ticks_ff, "tick counter not below ticks_per_unit")

   // an empty input register with no renormalization never stalls req
   `ETMC_ASSERT_NOW(a_no_spurious_stall, clock, reset, !s1_valid_ff && !norm_busy_ff, !req_stall, "req stalled while input register empty")

   // visible state changes only when a word completes
   `ETMC_ASSERT_NEXT(a_state_holds, clock, reset, !advance, $stable(state_ff.set_time) && $stable(state_ff.time_left) && $stable(state_ff.menu), "result state changed without a word")

endmodule

`default_nettype wire

/* sim/exposure_timer_menu_controller_tb.sv */
// self-checking testbench for the exposure timer menu controller
// depends on etmc_pkg and exposure_timer_menu_controller; a scoreboard class predicts
// every result word, plain tasks drive the req channel and the csr port
module exposure_timer_menu_controller_tb;
   import etmc_pkg::*;

   // generous cycle cap, far above the slowest legal run
   localparam int CYCLE_LIMIT = 200000;
   localparam int IDLE_PCT    = 12;

   typedef struct packed {
      etmc_menu_type     menu;
      logic [TIME_W-1:0] setpoint;
      logic [TIME_W-1:0] remaining;
      logic              running;
      logic              lamp;
   } etmc_result_type;

   // scoreboard: shadow of the controller state plus the queue of result words still owed
   class etmc_scoreboard;
      logic [TIME_W-1:0] max_time;
      logic [TICK_W-1:0] ticks;
      etmc_state_type    st;
      etmc_result_type   owed[$];
      int                errors;

      function new();
         max_time = MAX_TIME_RESET;
         ticks    = TICKS_RESET;
         st       = '0;
         errors   = 0;
      endfunction

      function int pending();
         return owed.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
         if (idx == CSR_MAX_TIME)
            max_time = data[TIME_W-1:0];
         else if (idx == CSR_TICKS)
            ticks = data[TICK_W-1:0];
      endfunction

      // advance the shadow state by one accepted word and queue the result it owes
      function void note_word(etmc_item_type w);
         etmc_result_type r;
         int step;
         int sum;
         int nxt;
         step = 0;
         if (w.cmd == CMD_TICK) begin
            if (st.run && st.time_left != 0) begin
               st.lamp = 1'b1;
               nxt = int'(st.tick) + 1;
               if (ticks != 0)
                  nxt = nxt % int'(ticks);
               else
                  nxt = nxt & 255;
               st.tick = nxt[TICK_W-1:0];
               if (st.tick == 0) begin
                  st.time_left = st.time_left - 1'b1;
                  if (st.time_left > max_time)
                     st.time_left = max_time;
               end
            end else begin
               st.lamp = 1'b0;
               st.tick = '0;
            end
         end else if (st.menu > MENU_CLEAR) begin
            st.menu = MENU_RUN_ENTRY;
         end else if (w.button) begin
            case (st.menu) inside
               MENU_RUN_ENTRY: begin
                  st.run       = 1'b1;
                  st.time_left = st.set_time;
                  st.menu      = MENU_RUN_VIEW;
               end
               MENU_RUN_VIEW: begin
                  st.run       = 1'b0;
                  st.time_left = '0;
                  st.menu      = MENU_RUN_ENTRY;
               end
               MENU_CLEAR: st.set_time = '0;
               MENU_SET_ENTRY, MENU_S1_ENTRY, MENU_S10_ENTRY, MENU_S100_ENTRY,
               MENU_S1000_ENTRY: st.menu = st.menu + 1'b1;
               default: st.menu = st.menu - 1'b1;
            endcase
         end else if (w.enc_moved) begin
            case (st.menu)
               MENU_RUN_ENTRY:   st.menu = MENU_SET_ENTRY;
               MENU_SET_ENTRY:   st.menu = MENU_RUN_ENTRY;
               MENU_SET_VIEW:    st.menu = w.enc_dir ? MENU_S1_ENTRY : MENU_CLEAR;
               MENU_S1_ENTRY:    st.menu = w.enc_dir ? MENU_S10_ENTRY : MENU_SET_VIEW;
               MENU_S10_ENTRY:   st.menu = w.enc_dir ? MENU_S100_ENTRY : MENU_S1_ENTRY;
               MENU_S100_ENTRY:  st.menu = w.enc_dir ? MENU_S1000_ENTRY : MENU_S10_ENTRY;
               MENU_S1000_ENTRY: st.menu = w.enc_dir ? MENU_CLEAR : MENU_S100_ENTRY;
               MENU_CLEAR:       st.menu = w.enc_dir ? MENU_SET_VIEW : MENU_S1000_ENTRY;
               MENU_S1_ADJ:      step = 1;
               MENU_S10_ADJ:     step = 10;
               MENU_S100_ADJ:    step = 100;
               MENU_S1000_ADJ:   step = 1000;
               default: ;
            endcase
            if (step != 0) begin
               // wide sum, clamped to 0..max_time
               sum = int'(st.set_time) + (w.enc_dir ? step : -step);
               if (sum < 0)
                  sum = 0;
               if (sum > int'(max_time))
                  sum = int'(max_time);
               st.set_time = sum[TIME_W-1:0];
            end
         end
         r.menu      = st.menu;
         r.setpoint  = st.set_time;
         r.remaining = st.time_left;
         r.running   = st.run;
         r.lamp      = st.lamp;
         owed.push_back(r);
      endfunction

      function void cmp_field(string name, int want, int got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check_result(etmc_result_type got);
         etmc_result_type want;
         if (owed.size() == 0) begin
            $error("result word with nothing owed");
            errors++;
            return;
         end
         want = owed.pop_front();
         cmp_field("menu_state", want.menu, got.menu);
         cmp_field("setpoint", want.setpoint, got.setpoint);
         cmp_field("remaining", want.remaining, got.remaining);
         cmp_field("running", want.running, got.running);
         cmp_field("lamp_on", want.lamp, got.lamp);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_cmd;
   logic                 req_button;
   logic                 req_enc_moved;
   logic                 req_enc_dir;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [MENU_W-1:0]    rsp_menu_state;
   logic [TIME_W-1:0]    rsp_setpoint;
   logic [TIME_W-1:0]    rsp_remaining;
   logic                 rsp_running;
   logic                 rsp_lamp_on;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]     csr_wdata;

   etmc_scoreboard sb = new();
   bit  idle_on;   // random gaps on req and random stalls on rsp
   int  cycles;

   exposure_timer_menu_controller uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_button     (req_button),
      .req_enc_moved  (req_enc_moved),
      .req_enc_dir    (req_enc_dir),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_menu_state (rsp_menu_state),
      .rsp_setpoint   (rsp_setpoint),
      .rsp_remaining  (rsp_remaining),
      .rsp_running    (rsp_running),
      .rsp_lamp_on    (rsp_lamp_on),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // cycle cap: a hung handshake ends the run here
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("exposure_timer_menu_controller_tb: done, errors");
         $finish;
      end
   end

   // sampled right after the edge, so these are the values the edge saw
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_word({req_cmd, req_button, req_enc_moved, req_enc_dir});
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result({rsp_menu_state, rsp_setpoint, rsp_remaining,
                          rsp_running, rsp_lamp_on});
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
   end

   // offer one word, with an optional idle gap in front; returns on the accepting edge
   task automatic send_word(input etmc_item_type w);
      int gap;
      gap = 0;
      if (idle_on)
         while ($urandom_range(99) < IDLE_PCT)
            gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      {req_cmd, req_button, req_enc_moved, req_enc_dir} <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // drain, let the pipe settle, then write both registers back to back
   task automatic set_config(input logic [TIME_W-1:0] max_val,
                             input logic [TICK_W-1:0] tpu_val);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= CSR_MAX_TIME;
      csr_wdata <= max_val;
      @(posedge clock);
      sb.write_reg(CSR_MAX_TIME, max_val);
      csr_index <= CSR_TICKS;
      csr_wdata <= {{(CSR_W-TICK_W){1'b0}}, tpu_val};
      @(posedge clock);
      sb.write_reg(CSR_TICKS, {{(CSR_W-TICK_W){1'b0}}, tpu_val});
      csr_write <= 1'b0;
   endtask

   // mostly well-formed menu traffic, some noise; up_pct biases the encoder direction
   task automatic run_random(input int count, input int tick_pct, input int up_pct);
      etmc_item_type w;
      int            pick;
      repeat (count) begin
         w = 4'($urandom);
         if ($urandom_range(99) < tick_pct) begin
            w.cmd = CMD_TICK;
         end else begin
            w.cmd = CMD_UI;
            pick  = $urandom_range(99);
            if (pick < 10) begin
               // noise: any mix of press and rotation
            end else if (pick < 35) begin
               w.button = 1'b1;
            end else if (pick < 92) begin
               w.button    = 1'b0;
               w.enc_moved = 1'b1;
               w.enc_dir   = ($urandom_range(99) < up_pct);
            end else begin
               w.button    = 1'b0;
               w.enc_moved = 1'b0;
            end
         end
         send_word(w);
      end
   endtask

   initial begin
      // words are {cmd, button, enc_moved, enc_dir}
      etmc_item_type opening[$] = '{
         4'b0000,  // idle sample changes nothing
         4'b1000,  // idle tick, lamp stays off
         4'b0011,  // run entry -> set entry
         4'b0100,  // -> set view
         4'b0010,  // down -> clear
         4'b0100,  // clear setpoint
         4'b0010,  // -> step-1000 entry
         4'b0111,  // press wins over rotation -> step-1000 adjust
         4'b0010,  // -1000 clamps at zero
         4'b0011,  // +1000
         4'b0011,  // +1000
         4'b0100,  // -> step-1000 entry
         4'b0010,  // -> step-100 entry
         4'b0101,  // -> step-100 adjust
         4'b0010,  // -100
         4'b0100,
         4'b0010,  // -> step-10 entry
         4'b0100,
         4'b0011,  // +10
         4'b0100,
         4'b0010,  // -> step-1 entry
         4'b0100,
         4'b0010,  // -1
         4'b0100,
         4'b0010,  // -> set view
         4'b0100,  // -> set entry
         4'b0010,  // -> run entry
         4'b0100,  // start
         4'b1000,
         4'b0011,  // rotation ignored in running view
         4'b0100,  // stop
         4'b1000   // lamp goes off on the next tick
      };
      // setpoint above a tiny max_time: start copies it as is, first decrement clamps
      etmc_item_type countdown[$] = '{
         4'b0100, 4'b1000, 4'b1000, 4'b1000, 4'b1000,
         4'b1000, 4'b1000, 4'b1000, 4'b0100, 4'b1000
      };
      logic [TIME_W-1:0] max_tbl[7] = '{15'd0, 15'd32767, 15'd25, 15'd60,
                                        15'd1500, 15'd32767, 15'd200};
      logic [TICK_W-1:0] tpu_tbl[7] = '{8'd1, 8'd255, 8'd1, 8'd2, 8'd4, 8'd1, 8'd255};
      int                up_tbl[7]  = '{50, 50, 50, 60, 85, 90, 50};

      cycles        <= 0;
      idle_on       <= 1'b0;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_cmd       <= CMD_UI;
      req_button    <= 1'b0;
      req_enc_moved <= 1'b0;
      req_enc_dir   <= 1'b0;
      rsp_stall     <= 1'b0;
      csr_write     <= 1'b0;
      csr_index     <= CSR_MAX_TIME;
      csr_wdata     <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      idle_on <= 1'b1;

      set_config(MAX_TIME_RESET, TICKS_RESET);
      foreach (opening[i]) send_word(opening[i]);

      set_config(15'd5, 8'd1);
      foreach (countdown[i]) send_word(countdown[i]);

      // random phases; the fifth runs with no gaps and no stalls at all
      foreach (max_tbl[p]) begin
         set_config(max_tbl[p], tpu_tbl[p]);
         idle_on <= (p != 4);
         run_random(150, 35, up_tbl[p]);
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("exposure_timer_menu_controller_tb: done, clean");
      else
         $display("exposure_timer_menu_controller_tb: done, errors");
      $finish;
   end

endmodule
